// ===== hdl/batch_norm_inference_2d_defines.svh =====
// ---------------------------------------------------------------------------
// Batch norm inference assertion macros
// Concurrent assertion wrappers, empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef BATCH_NORM_INFERENCE_2D_DEFINES_SVH
`define BATCH_NORM_INFERENCE_2D_DEFINES_SVH
`ifndef SYNTHESIS
`define BNI_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define BNI_ASSERT(lbl, prop) `BNI_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define BNI_ASSERT_CLK(lbl, clk, rstn, prop)
`define BNI_ASSERT(lbl, prop)
`endif
`endif

// ===== hdl/bni_pkg.sv =====
// ---------------------------------------------------------------------------
// Batch norm inference package
// Shared widths, register codes and reset values.
// ---------------------------------------------------------------------------
package bni_pkg;
  localparam int unsigned MaxChannelsDef = 256;
  localparam int unsigned RsqrtStepsDef  = 24;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 17;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_PLANE_SIZE    = 2'd1,
    REG_EPS           = 2'd2
  } reg_idx_e;

  localparam logic [8:0]  ChannelCountRst = 9'd1;
  localparam logic [16:0] PlaneSizeRst    = 17'd1;
  localparam logic [15:0] EpsRst          = 16'd1;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpSample = 1'b1;
endpackage

// ===== hdl/batch_norm_inference_2d.sv =====
// ---------------------------------------------------------------------------
// Batch norm inference, 2D
// Per-channel normalization of a sample stream with stored channel params.
// ---------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): op_i selects a load of one
// channel's mean, variance, scale and shift, or a sample to normalize.
// Output channel (out_valid_o / out_stall_i): one item per sample, none
// per load. Config port (cfg_valid_i / cfg_ready_o) writes channel_count,
// plane_size and eps; write only while the block is idle.
// One item is in flight at a time. A sample passes the parameter memory
// read, two multiplies, then round and saturate into the output register;
// the next item is accepted only once the block is back in idle.
// A load holds the input while a one-bit-per-cycle divider forms
// 2^48/(variance+eps), then a one-bit-per-cycle root search builds
// inv_std, and the entry is written to the parameter memory in the last
// root cycle.
// The output register holds a finished item while out_valid_o is stalled;
// a new input is accepted meanwhile, and a finished sample waits in its
// last stage until the output register frees up.
// Reset clears the counters and registers to channel_count 1, plane_size
// 1, eps 1; parameter memory is not cleared and must be loaded first.
// ---------------------------------------------------------------------------
`include "batch_norm_inference_2d_defines.svh"

module batch_norm_inference_2d #(
  parameter int unsigned MAX_CHANNELS = bni_pkg::MaxChannelsDef,
  parameter int unsigned RSQRT_STEPS  = bni_pkg::RsqrtStepsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic [7:0]                   load_channel_i,
  input  logic signed [15:0]           mean_in_i,
  input  logic [31:0]                  variance_in_i,
  input  logic signed [15:0]           scale_in_i,
  input  logic signed [15:0]           shift_in_i,
  input  logic signed [15:0]           sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [15:0]           out_value_o,
  output logic [7:0]                   out_channel_o,
  output logic                         plane_end_o,
  output logic                         saturated_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bni_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bni_pkg::CfgDataW-1:0] cfg_data_i
);
  localparam int unsigned AddrW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned RootSteps = (RSQRT_STEPS > 24) ? 24 : RSQRT_STEPS;
  localparam logic [5:0]  DivLast   = 6'd48;
  localparam logic [5:0]  RootLast  = 6'(RootSteps - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_ROOT, S_MUL1, S_MUL2, S_DONE
  } state_e;

  typedef struct packed {
    logic signed [15:0] mean;
    logic [23:0]        inv_std;
    logic signed [15:0] scale;
    logic signed [15:0] shift;
  } chan_word_t;

  state_e state_q;
  logic [8:0]  chan_count_q;
  logic [16:0] plane_size_q;
  logic [15:0] eps_q;
  logic [15:0] plane_pos_q;
  logic [7:0]  cur_chan_q;

  chan_word_t  chan_mem_q [MAX_CHANNELS];
  chan_word_t  rd_q;
  logic signed [15:0] ld_mean_q;
  logic signed [15:0] ld_scale_q;
  logic signed [15:0] ld_shift_q;
  logic [23:0] ld_inv;
  chan_word_t  wr_word;
  logic [AddrW-1:0] ld_addr_q;
  logic        ld_ok_q;
  logic        mem_we;

  logic [32:0] s_q;
  logic [33:0] rem_q;
  logic [48:0] quo_q;
  logic [5:0]  cnt_q;
  logic [23:0] root_q;
  logic [23:0] mask_q;
  logic [48:0] sq_q;
  logic [48:0] t_q;
  logic [48:0] u_q;

  logic signed [15:0] sample_q;
  logic [7:0]  chan_q;
  logic        end_q;
  logic signed [41:0] p1_q;
  logic signed [57:0] p2_q;

  logic signed [15:0] out_value_q;
  logic [7:0]  out_chan_q;
  logic        out_end_q;
  logic        out_sat_q;
  logic        out_valid_q;

  logic        in_acc;
  logic        out_free;
  logic [8:0]  ch_count;
  logic [16:0] p_size;
  logic [33:0] rem_sh;
  logic        rem_ge;
  logic [48:0] cand_sq;
  logic        keep;
  logic signed [16:0] diff;
  logic signed [58:0] acc;
  logic signed [34:0] y;
  logic signed [15:0] y_sat;
  logic        y_clip;
  logic        pos_end;
  logic [8:0]  ch_next;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign ch_count = (chan_count_q == 9'd0) ? 9'd1 :
                    (chan_count_q > 9'd256) ? 9'd256 : chan_count_q;
  assign p_size   = (plane_size_q == 17'd0) ? 17'd1 :
                    (plane_size_q > 17'd65536) ? 17'd65536 : plane_size_q;
  assign pos_end  = ({1'b0, plane_pos_q} + 17'd1) >= p_size;
  assign ch_next  = {1'b0, cur_chan_q} + 9'd1;

  // divider step: shift in the next dividend bit (2^48 has only its top bit)
  assign rem_sh = {rem_q[32:0], (cnt_q == DivLast)};
  assign rem_ge = rem_sh >= {1'b0, s_q};

  // root step: (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b)
  assign cand_sq = sq_q + t_q + u_q;
  assign keep    = cand_sq <= quo_q;

  assign diff   = 17'(sample_q) - 17'(rd_q.mean);
  assign acc    = 59'(p2_q) + (59'(rd_q.shift) <<< 24) + (59'(1) <<< 23);
  assign y      = 35'(acc >>> 24);
  assign y_clip = (y > 35'sd32767) || (y < -35'sd32768);
  assign y_sat  = (y > 35'sd32767) ? 16'sh7fff :
                  (y < -35'sd32768) ? -16'sh8000 : 16'(y);

  assign mem_we = (state_q == S_ROOT) && (cnt_q == RootLast) && ld_ok_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      chan_mem_q[ld_addr_q] <= wr_word;
    end
    if (in_acc && (op_i == bni_pkg::OpSample)) begin
      if (32'(cur_chan_q) < 32'(MAX_CHANNELS)) begin
        rd_q <= chan_mem_q[AddrW'(cur_chan_q)];
      end else begin
        rd_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      chan_count_q <= bni_pkg::ChannelCountRst;
      plane_size_q <= bni_pkg::PlaneSizeRst;
      eps_q        <= bni_pkg::EpsRst;
      plane_pos_q  <= '0;
      cur_chan_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          bni_pkg::REG_CHANNEL_COUNT: chan_count_q <= cfg_data_i[8:0];
          bni_pkg::REG_PLANE_SIZE:    plane_size_q <= cfg_data_i;
          bni_pkg::REG_EPS:           eps_q        <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      // drop the taken item unless the last stage refills the register now
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (op_i == bni_pkg::OpLoad) begin
              ld_mean_q  <= mean_in_i;
              ld_scale_q <= scale_in_i;
              ld_shift_q <= shift_in_i;
              ld_addr_q  <= AddrW'(load_channel_i);
              ld_ok_q    <= 32'(load_channel_i) < 32'(MAX_CHANNELS);
              s_q        <= 33'(variance_in_i) + 33'(eps_q);
              rem_q      <= '0;
              quo_q      <= '0;
              cnt_q      <= DivLast;
              state_q    <= S_DIV;
            end else begin
              sample_q <= sample_i;
              chan_q   <= cur_chan_q;
              end_q    <= pos_end;
              if (pos_end) begin
                plane_pos_q <= '0;
                cur_chan_q  <= (ch_next >= ch_count) ? 8'd0 : ch_next[7:0];
              end else begin
                plane_pos_q <= plane_pos_q + 16'd1;
              end
              state_q <= S_MUL1;
            end
          end
        end
        S_DIV: begin
          // cnt_q counts dividend bit positions down to zero
          rem_q <= rem_ge ? (rem_sh - {1'b0, s_q}) : rem_sh;
          quo_q <= {quo_q[47:0], rem_ge};
          if (cnt_q == 6'd0) begin
            cnt_q   <= '0;
            root_q  <= '0;
            mask_q  <= 24'h800000;
            sq_q    <= '0;
            t_q     <= '0;
            u_q     <= 49'(1) << 46;
            state_q <= S_ROOT;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        S_ROOT: begin
          if (keep) begin
            sq_q   <= cand_sq;
            root_q <= root_q | mask_q;
            t_q    <= (t_q >> 1) + u_q;
          end else begin
            t_q <= t_q >> 1;
          end
          u_q    <= u_q >> 2;
          mask_q <= mask_q >> 1;
          if (cnt_q == RootLast) begin
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_MUL1: begin
          p1_q    <= 42'(diff * $signed({1'b0, rd_q.inv_std}));
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          p2_q    <= 58'(p1_q * rd_q.scale);
          state_q <= S_DONE;
        end
        S_DONE: begin
          // hold here until the output register frees up
          if (out_free) begin
            out_value_q <= y_sat;
            out_chan_q  <= chan_q;
            out_end_q   <= end_q;
            out_sat_q   <= y_clip;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // keep the final root, or saturate when variance plus eps is zero
  always_comb begin
    ld_inv  = (s_q == 33'd0) ? 24'hffffff :
              ((keep && (state_q == S_ROOT)) ? (root_q | mask_q) : root_q);
    wr_word = '{mean: ld_mean_q, inv_std: ld_inv, scale: ld_scale_q, shift: ld_shift_q};
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign out_channel_o = out_chan_q;
  assign plane_end_o   = out_end_q;
  assign saturated_o   = out_sat_q;

  `BNI_ASSERT(a_div_rem_below_divisor,
    ((state_q == S_DIV) && (s_q != 33'd0)) |-> (rem_q < {1'b0, s_q}))
  `BNI_ASSERT(a_load_no_result,
    (in_acc && (op_i == bni_pkg::OpLoad) && !out_valid_q) |=> !out_valid_q)
  `BNI_ASSERT(a_sample_reads_memory,
    (in_acc && (op_i == bni_pkg::OpSample)) |=> (state_q == S_MUL1))
endmodule
